>>> design/bsc_pkg.sv
package bsc_pkg;

    localparam int MAX_POINTS_DEF = 64;
    localparam int MAX_DEGREE_DEF = 7;
    localparam int FRAC_BITS_DEF  = 16;

    localparam int KIND_W  = 2;
    localparam int INDEX_W = 7;
    localparam int COORD_W = 32;
    localparam int KNOT_W  = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 7;
    localparam int DEG_W   = 3;
    localparam int COUNT_W = 7;

    localparam logic [DEG_W-1:0]   DEGREE_RST = 3'd3;
    localparam logic [COUNT_W-1:0] COUNT_RST  = 7'd0;
    localparam logic               MODE_RST   = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_POINT = 2'd0,
        KIND_KNOT  = 2'd1,
        KIND_EVAL  = 2'd2,
        KIND_NONE  = 2'd3
    } t_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DEGREE = 2'd0,
        CFG_COUNT  = 2'd1,
        CFG_MODE   = 2'd2,
        CFG_NONE   = 2'd3
    } t_cfg;

endpackage

>>> design/bsc_div.sv
module bsc_div
    import bsc_pkg::*;
#(
    parameter int W  = 25,
    parameter int QW = FRAC_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [W-1:0]  i_num,
    input  logic [W-1:0]  i_den,
    output logic          o_done,
    output logic [QW-1:0] o_quot
);

    localparam int CNT_W = $clog2(QW + 1);

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [W-1:0]     r_rem;
    logic [W-1:0]     r_den;
    logic [QW-1:0]    r_q;
    logic [W:0]       shifted;
    logic [W:0]       diff;
    logic             ge;

    // The numerator is always below the denominator, so each step yields
    // one fraction bit of the quotient.
    always_comb begin
        shifted = {r_rem, 1'b0};
        diff    = shifted - {1'b0, r_den};
        ge      = (shifted >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(QW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num;
            r_den <= i_den;
        end else if (r_busy) begin
            r_rem <= ge ? diff[W-1:0] : shifted[W-1:0];
            r_q   <= {r_q[QW-2:0], ge};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

>>> design/bsc_lerp.sv
module bsc_lerp
    import bsc_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [COORD_W-1:0] i_a,
    input  logic [COORD_W-1:0] i_b,
    input  logic [FRAC_BITS:0] i_w,
    output logic               o_valid,
    output logic [COORD_W-1:0] o_res
);

    localparam int PW = COORD_W + FRAC_BITS + 3;

    logic                 r_v1;
    logic                 r_v2;
    logic signed [PW-1:0] r_prod;
    logic signed [PW-1:0] r_base;
    logic [COORD_W-1:0]   r_res;
    logic signed [COORD_W:0]    diff;
    logic signed [FRAC_BITS+1:0] w_s;
    logic signed [PW-1:0] prod;
    logic signed [PW-1:0] sum;

    // a*(1-w) + b*w equals a*one + (b-a)*w exactly; the final arithmetic
    // shift gives round to nearest with ties upward.
    always_comb begin
        diff = $signed({i_b[COORD_W-1], i_b}) - $signed({i_a[COORD_W-1], i_a});
        w_s  = $signed({1'b0, i_w});
        prod = PW'(diff) * PW'(w_s);
        sum  = r_base + r_prod + (PW'(1) <<< (FRAC_BITS - 1));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= prod;
        r_base <= PW'($signed(i_a)) <<< FRAC_BITS;
        r_res  <= sum[FRAC_BITS+COORD_W-1:FRAC_BITS];
    end

    assign o_valid = r_v2;
    assign o_res   = r_res;

endmodule

>>> design/bspline_curve_evaluator_top.sv
// B-spline curve evaluator. Load transactions (kind 0 point, kind 1 knot) are written
// straight into the point or knot memory. An evaluate transaction searches the knot
// vector for the span holding the parameter and then runs de Boor's recurrence, while
// the input stalls. With explicit knots the search reads each knot from the knot memory;
// in uniform mode each inner knot comes from the shared 1-bit-per-cycle divider.
// Each of the d*(d+1)/2 recurrence steps fetches two knots, may run one more division
// for its weight, and then runs the three coordinates through the single two-stage
// multiply-add unit. The result is held in an output register, so the next
// transaction is taken while it waits.
module bspline_curve_evaluator_top
    import bsc_pkg::*;
#(
    parameter int MAX_POINTS = MAX_POINTS_DEF,
    parameter int MAX_DEGREE = MAX_DEGREE_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [KIND_W-1:0]     i_kind,
    input  logic [INDEX_W-1:0]    i_index,
    input  logic [COORD_W-1:0]    i_coord_x,
    input  logic [COORD_W-1:0]    i_coord_y,
    input  logic [COORD_W-1:0]    i_coord_z,
    input  logic [KNOT_W-1:0]     i_knot_value,
    input  logic [KNOT_W-1:0]     i_param,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [COORD_W-1:0]    o_point_x,
    output logic [COORD_W-1:0]    o_point_y,
    output logic [COORD_W-1:0]    o_point_z,
    output logic                  o_in_range
);

    localparam int KD = MAX_POINTS + MAX_DEGREE + 1;
    localparam int KW = $clog2(KD);
    localparam int CW = $clog2(KD + 1);
    localparam int PAW = $clog2(MAX_POINTS);
    localparam int NW = $clog2(MAX_POINTS + 1);
    localparam int DW = $clog2(MAX_DEGREE + 1);
    localparam int TW = (FRAC_BITS + 1 > KNOT_W) ? FRAC_BITS + 1 : KNOT_W;
    localparam logic [TW-1:0] ONE_T = TW'(1) << FRAC_BITS;
    localparam logic [FRAC_BITS:0] ONE_W = (FRAC_BITS + 1)'(1) << FRAC_BITS;

    typedef enum logic [20:0] {
        S_IDLE    = 21'h000001,
        S_EVSTART = 21'h000002,
        S_FETCH   = 21'h000004,
        S_FWAIT   = 21'h000008,
        S_FDIV    = 21'h000010,
        S_SRCH0   = 21'h000020,
        S_SRCH    = 21'h000040,
        S_CHECK   = 21'h000080,
        S_CPRD    = 21'h000100,
        S_CPWR    = 21'h000200,
        S_RECK    = 21'h000400,
        S_WTJ     = 21'h000800,
        S_WTK     = 21'h001000,
        S_WCALC   = 21'h002000,
        S_WDIV    = 21'h004000,
        S_LRD     = 21'h008000,
        S_LGO     = 21'h010000,
        S_LWAIT   = 21'h020000,
        S_OUTRD   = 21'h040000,
        S_OUTWR   = 21'h080000,
        S_FIN     = 21'h100000
    } t_state;

    typedef enum logic [1:0] {
        RET_SRCH0 = 2'd0,
        RET_SRCH  = 2'd1,
        RET_TJ    = 2'd2,
        RET_TK    = 2'd3
    } t_ret;

    t_state r_state, n_state, ret_st;
    t_ret   r_ret, n_ret;

    logic [DEG_W-1:0]   r_deg, n_deg;
    logic [COUNT_W-1:0] r_pc, n_pc;
    logic               r_mode, n_mode;
    logic [KNOT_W-1:0]  r_x, n_x;
    logic [DW-1:0]      r_d, n_d;
    logic [NW-1:0]      r_n, n_n;
    logic [CW-1:0]      r_kidx, n_kidx;
    logic [CW-1:0]      r_i, n_i;
    logic [TW-1:0]      r_knot, n_knot;
    logic [TW-1:0]      r_tprev, n_tprev;
    logic [TW-1:0]      r_tj, n_tj;
    logic [FRAC_BITS:0] r_w, n_w;
    logic [DW-1:0]      r_m, n_m;
    logic [DW-1:0]      r_k, n_k;
    logic [DW-1:0]      r_li, n_li;
    logic [1:0]         r_c, n_c;
    logic [COORD_W-1:0] r_res_x, n_res_x, r_res_y, n_res_y, r_res_z, n_res_z;
    logic               r_res_in, n_res_in;
    logic               r_out_valid, n_out_valid;
    logic [COORD_W-1:0] r_ox, n_ox, r_oy, n_oy, r_oz, n_oz;
    logic               r_oin, n_oin;

    logic [COORD_W-1:0] pts_x [MAX_POINTS];
    logic [COORD_W-1:0] pts_y [MAX_POINTS];
    logic [COORD_W-1:0] pts_z [MAX_POINTS];
    logic [KNOT_W-1:0]  knot_mem [KD];
    logic [COORD_W-1:0] sc_x [MAX_DEGREE+1];
    logic [COORD_W-1:0] sc_y [MAX_DEGREE+1];
    logic [COORD_W-1:0] sc_z [MAX_DEGREE+1];

    logic [COORD_W-1:0] r_pq_x, r_pq_y, r_pq_z;
    logic [KNOT_W-1:0]  r_kq;
    logic [COORD_W-1:0] r_sa_x, r_sa_y, r_sa_z, r_sb_x, r_sb_y, r_sb_z;

    logic               in_acc;
    logic               pt_we, kn_we;
    logic [PAW-1:0]     pt_raddr;
    logic               sc_we_x, sc_we_y, sc_we_z;
    logic [DW-1:0]      sc_waddr;
    logic [COORD_W-1:0] sc_wx, sc_wy, sc_wz;
    logic [DW-1:0]      sc_rb;

    logic               div_start, div_done;
    logic [TW-1:0]      div_num, div_den;
    logic [FRAC_BITS-1:0] div_q;
    logic               lerp_valid, lerp_done;
    logic [COORD_W-1:0] lerp_a, lerp_b, lerp_res;

    logic [TW-1:0]      xe;
    logic [CW-1:0]      nk;
    logic signed [TW:0] wnum, wden;
    logic [DW-1:0]      d_sat;
    logic [NW-1:0]      n_sat;

    bsc_div #(.W(TW), .QW(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quot  (div_q)
    );

    bsc_lerp #(.FRAC_BITS(FRAC_BITS)) u_lerp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (lerp_valid),
        .i_a     (lerp_a),
        .i_b     (lerp_b),
        .i_w     (r_w),
        .o_valid (lerp_done),
        .o_res   (lerp_res)
    );

    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_point_x   = r_ox;
    assign o_point_y   = r_oy;
    assign o_point_z   = r_oz;
    assign o_in_range  = r_oin;

    always_comb begin
        xe    = TW'(r_x);
        nk    = CW'(r_n) + CW'(r_d) + CW'(1);
        wnum  = $signed({1'b0, xe}) - $signed({1'b0, r_tj});
        wden  = $signed({1'b0, r_knot}) - $signed({1'b0, r_tj});
        d_sat = (32'(r_deg) > 32'(MAX_DEGREE)) ? DW'(MAX_DEGREE) : DW'(r_deg);
        n_sat = (32'(r_pc) > 32'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(r_pc);
        pt_raddr = PAW'(r_i - CW'(r_d) + CW'(r_m));
        sc_rb = r_li + DW'(1);
        pt_we = in_acc && (i_kind == KIND_POINT) && (32'(i_index) < 32'(MAX_POINTS));
        kn_we = in_acc && (i_kind == KIND_KNOT) && (32'(i_index) < 32'(KD));
        case (r_c)
            2'd0:    begin lerp_a = r_sa_x; lerp_b = r_sb_x; end
            2'd1:    begin lerp_a = r_sa_y; lerp_b = r_sb_y; end
            default: begin lerp_a = r_sa_z; lerp_b = r_sb_z; end
        endcase
        case (r_ret)
            RET_SRCH0: ret_st = S_SRCH0;
            RET_SRCH:  ret_st = S_SRCH;
            RET_TJ:    ret_st = S_WTK;
            default:   ret_st = S_WCALC;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_ret   = r_ret;
        n_deg   = r_deg;
        n_pc    = r_pc;
        n_mode  = r_mode;
        n_x     = r_x;
        n_d     = r_d;
        n_n     = r_n;
        n_kidx  = r_kidx;
        n_i     = r_i;
        n_knot  = r_knot;
        n_tprev = r_tprev;
        n_tj    = r_tj;
        n_w     = r_w;
        n_m     = r_m;
        n_k     = r_k;
        n_li    = r_li;
        n_c     = r_c;
        n_res_x = r_res_x;
        n_res_y = r_res_y;
        n_res_z = r_res_z;
        n_res_in = r_res_in;
        n_out_valid = r_out_valid && i_out_stall;
        n_ox    = r_ox;
        n_oy    = r_oy;
        n_oz    = r_oz;
        n_oin   = r_oin;
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        lerp_valid = 1'b0;
        sc_we_x  = 1'b0;
        sc_we_y  = 1'b0;
        sc_we_z  = 1'b0;
        sc_waddr = r_li;
        sc_wx    = lerp_res;
        sc_wy    = lerp_res;
        sc_wz    = lerp_res;

        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_DEGREE: n_deg  = i_cfg_data[DEG_W-1:0];
                CFG_COUNT:  n_pc   = i_cfg_data[COUNT_W-1:0];
                CFG_MODE:   n_mode = i_cfg_data[0];
                default:    ;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (in_acc && i_kind == KIND_EVAL) begin
                    n_x     = i_param;
                    n_d     = d_sat;
                    n_n     = n_sat;
                    n_state = S_EVSTART;
                end
            end
            S_EVSTART: begin
                if ((r_mode && (CW'(r_n) < CW'(r_d) + CW'(1))) || (nk < CW'(2))) begin
                    n_res_x  = '0;
                    n_res_y  = '0;
                    n_res_z  = '0;
                    n_res_in = 1'b0;
                    n_state  = S_FIN;
                end else begin
                    n_i     = '0;
                    n_kidx  = '0;
                    n_ret   = RET_SRCH0;
                    n_state = S_FETCH;
                end
            end
            S_FETCH: begin
                if (!r_mode) begin
                    n_state = S_FWAIT;
                end else if (r_kidx <= CW'(r_d)) begin
                    n_knot  = '0;
                    n_state = ret_st;
                end else if (r_kidx >= CW'(r_n)) begin
                    n_knot  = ONE_T;
                    n_state = ret_st;
                end else begin
                    div_start = 1'b1;
                    div_num   = TW'(r_kidx - CW'(r_d));
                    div_den   = TW'(CW'(r_n) - CW'(r_d));
                    n_state   = S_FDIV;
                end
            end
            S_FWAIT: begin
                n_knot  = TW'(r_kq);
                n_state = ret_st;
            end
            S_FDIV: begin
                if (div_done) begin
                    n_knot  = TW'(div_q);
                    n_state = ret_st;
                end
            end
            S_SRCH0: begin
                n_tprev = r_knot;
                n_kidx  = CW'(1);
                n_ret   = RET_SRCH;
                n_state = S_FETCH;
            end
            S_SRCH: begin
                if (r_tprev <= xe && xe < r_knot) begin
                    n_state = S_CHECK;
                end else begin
                    n_tprev = r_knot;
                    n_i     = r_i + CW'(1);
                    if (r_i + CW'(2) < nk) begin
                        n_kidx  = r_i + CW'(2);
                        n_state = S_FETCH;
                    end else begin
                        n_res_x  = '0;
                        n_res_y  = '0;
                        n_res_z  = '0;
                        n_res_in = 1'b0;
                        n_state  = S_FIN;
                    end
                end
            end
            S_CHECK: begin
                if (r_i < CW'(r_d) || r_i >= CW'(r_n)) begin
                    n_res_x  = '0;
                    n_res_y  = '0;
                    n_res_z  = '0;
                    n_res_in = 1'b0;
                    n_state  = S_FIN;
                end else begin
                    n_m     = '0;
                    n_state = S_CPRD;
                end
            end
            S_CPRD: n_state = S_CPWR;
            S_CPWR: begin
                sc_we_x  = 1'b1;
                sc_we_y  = 1'b1;
                sc_we_z  = 1'b1;
                sc_waddr = r_m;
                sc_wx    = r_pq_x;
                sc_wy    = r_pq_y;
                sc_wz    = r_pq_z;
                if (r_m == r_d) begin
                    n_k     = r_d;
                    n_state = S_RECK;
                end else begin
                    n_m     = r_m + DW'(1);
                    n_state = S_CPRD;
                end
            end
            S_RECK: begin
                n_li    = '0;
                n_state = (r_k == '0) ? S_OUTRD : S_WTJ;
            end
            S_WTJ: begin
                n_kidx  = r_i - CW'(r_k) + CW'(1) + CW'(r_li);
                n_ret   = RET_TJ;
                n_state = S_FETCH;
            end
            S_WTK: begin
                n_tj    = r_knot;
                n_kidx  = r_kidx + CW'(r_k);
                n_ret   = RET_TK;
                n_state = S_FETCH;
            end
            S_WCALC: begin
                if (wden <= 0 || wnum <= 0) begin
                    n_w     = '0;
                    n_state = S_LRD;
                end else if (wnum >= wden) begin
                    n_w     = ONE_W;
                    n_state = S_LRD;
                end else begin
                    div_start = 1'b1;
                    div_num   = wnum[TW-1:0];
                    div_den   = wden[TW-1:0];
                    n_state   = S_WDIV;
                end
            end
            S_WDIV: begin
                if (div_done) begin
                    n_w     = {1'b0, div_q};
                    n_state = S_LRD;
                end
            end
            S_LRD: begin
                n_c     = 2'd0;
                n_state = S_LGO;
            end
            S_LGO: begin
                lerp_valid = 1'b1;
                n_state    = S_LWAIT;
            end
            S_LWAIT: begin
                if (lerp_done) begin
                    sc_we_x = (r_c == 2'd0);
                    sc_we_y = (r_c == 2'd1);
                    sc_we_z = (r_c == 2'd2);
                    if (r_c == 2'd2) begin
                        if (sc_rb == r_k) begin
                            n_k     = r_k - DW'(1);
                            n_state = S_RECK;
                        end else begin
                            n_li    = sc_rb;
                            n_state = S_WTJ;
                        end
                    end else begin
                        n_c     = r_c + 2'd1;
                        n_state = S_LGO;
                    end
                end
            end
            S_OUTRD: n_state = S_OUTWR;
            S_OUTWR: begin
                n_res_x  = r_sa_x;
                n_res_y  = r_sa_y;
                n_res_z  = r_sa_z;
                n_res_in = 1'b1;
                n_state  = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid = 1'b1;
                    n_ox    = r_res_x;
                    n_oy    = r_res_y;
                    n_oz    = r_res_z;
                    n_oin   = r_res_in;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_deg       <= DEGREE_RST;
            r_pc        <= COUNT_RST;
            r_mode      <= MODE_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_deg       <= n_deg;
            r_pc        <= n_pc;
            r_mode      <= n_mode;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ret    <= n_ret;
        r_x      <= n_x;
        r_d      <= n_d;
        r_n      <= n_n;
        r_kidx   <= n_kidx;
        r_i      <= n_i;
        r_knot   <= n_knot;
        r_tprev  <= n_tprev;
        r_tj     <= n_tj;
        r_w      <= n_w;
        r_m      <= n_m;
        r_k      <= n_k;
        r_li     <= n_li;
        r_c      <= n_c;
        r_res_x  <= n_res_x;
        r_res_y  <= n_res_y;
        r_res_z  <= n_res_z;
        r_res_in <= n_res_in;
        r_ox     <= n_ox;
        r_oy     <= n_oy;
        r_oz     <= n_oz;
        r_oin    <= n_oin;
    end

    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            pts_x[PAW'(i_index)] <= i_coord_x;
            pts_y[PAW'(i_index)] <= i_coord_y;
            pts_z[PAW'(i_index)] <= i_coord_z;
        end
        r_pq_x <= pts_x[pt_raddr];
        r_pq_y <= pts_y[pt_raddr];
        r_pq_z <= pts_z[pt_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (kn_we) begin
            knot_mem[KW'(i_index)] <= i_knot_value;
        end
        r_kq <= knot_mem[r_kidx[KW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (sc_we_x) begin
            sc_x[sc_waddr] <= sc_wx;
        end
        if (sc_we_y) begin
            sc_y[sc_waddr] <= sc_wy;
        end
        if (sc_we_z) begin
            sc_z[sc_waddr] <= sc_wz;
        end
        r_sa_x <= sc_x[r_li];
        r_sa_y <= sc_y[r_li];
        r_sa_z <= sc_z[r_li];
        r_sb_x <= sc_x[sc_rb];
        r_sb_y <= sc_y[sc_rb];
        r_sb_z <= sc_z[sc_rb];
    end

endmodule

>>> design/bsc_checker.sv
module bsc_checker
    import bsc_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic [KIND_W-1:0]     i_kind,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input logic [COORD_W-1:0]    o_point_x,
    input logic [COORD_W-1:0]    o_point_y,
    input logic [COORD_W-1:0]    o_point_z,
    input logic                  o_in_range
);

    // A result without a span must be the zero point.
    a_zero_when_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_in_range) |->
            (o_point_x == '0 && o_point_y == '0 && o_point_z == '0))
        else $error("out-of-range result is not zero");

    // An evaluate transaction occupies the block for at least the next cycle.
    a_eval_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_kind == KIND_EVAL) |=> o_in_stall)
        else $error("block took a transaction right after an evaluate");

    // Load transactions never produce a result.
    a_load_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && i_kind != KIND_EVAL && !o_out_valid)
            |=> !o_out_valid)
        else $error("result appeared after a load transaction");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
            (o_out_valid && $stable(o_point_x) && $stable(o_point_y)
             && $stable(o_point_z) && $stable(o_in_range)))
        else $error("stalled result changed");

endmodule

bind bspline_curve_evaluator_top bsc_checker u_bsc_checker (.*);
